// ===== rtl/bwfm_pkg.sv =====
// ============================================================================
// bwfm_pkg - shared constants for the butterworth frequency mask
// fixed-point widths, filter kind codes and configuration register indexes
// ============================================================================
package bwfm_pkg;

    // gain format: unsigned, GAIN_F fraction bits
    localparam int GAIN_F = 16;
    localparam int GAIN_W = GAIN_F + 1;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_F;

    // ratio and power format, saturates at 2^(63-F) - 1
    localparam int RATIO_W = 63 - GAIN_F;
    localparam logic [RATIO_W-1:0] RATIO_CAP = {RATIO_W{1'b1}};

    // split point of the ratio multiplier
    localparam int MUL_LO_W = RATIO_W / 2;
    localparam int MUL_HI_W = RATIO_W - MUL_LO_W;

    // ratio numerator and denominator widths
    localparam int NUM_W = 40;
    localparam int DEN_W = 43;

    // gain divider denominator width (1.0 + power)
    localparam int GDEN_W = RATIO_W + 1;

    // highest butterworth order
    localparam int MAX_ORDER = 15;

    // payload widths
    localparam int COORD_W = 10;
    localparam int CFG_W   = 10;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // filter kinds
    localparam logic [2:0] KIND_LOWPASS    = 3'd0;
    localparam logic [2:0] KIND_HIGHPASS   = 3'd1;
    localparam logic [2:0] KIND_BANDREJECT = 3'd2;
    localparam logic [2:0] KIND_BANDPASS   = 3'd3;
    localparam logic [2:0] KIND_NOTCH      = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_KIND    = 3'd0;
    localparam logic [2:0] CFG_RADIUS  = 3'd1;
    localparam logic [2:0] CFG_ORDER   = 3'd2;
    localparam logic [2:0] CFG_BAND    = 3'd3;
    localparam logic [2:0] CFG_NOTCH_U = 3'd4;
    localparam logic [2:0] CFG_NOTCH_V = 3'd5;

endpackage

// ===== rtl/bwfm_div_pipe.sv =====
// ============================================================================
// bwfm_div_pipe - pipelined restoring divider
// one quotient bit per stage, partial remainder starts below the divisor
// ============================================================================
module bwfm_div_pipe #(
    parameter int DEN_W  = 43,
    parameter int Q_W    = 47,
    parameter int SIDE_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [Q_W-1:0]    in_nlo,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg  [Q_W];
    logic [DEN_W-1:0]  rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    nlo_reg  [Q_W];
    logic [Q_W-1:0]    quot_reg [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic              p_vld;
        logic [DEN_W-1:0]  p_rem;
        logic [DEN_W-1:0]  p_den;
        logic [Q_W-1:0]    p_nlo;
        logic [Q_W-1:0]    p_quot;
        logic [SIDE_W-1:0] p_side;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;

        if (i == 0) begin : g_first
            assign p_vld  = in_valid;
            assign p_rem  = in_rem;
            assign p_den  = in_den;
            assign p_nlo  = in_nlo;
            assign p_quot = '0;
            assign p_side = in_side;
        end
        else begin : g_next
            assign p_vld  = vld_reg[i-1];
            assign p_rem  = rem_reg[i-1];
            assign p_den  = den_reg[i-1];
            assign p_nlo  = nlo_reg[i-1];
            assign p_quot = quot_reg[i-1];
            assign p_side = side_reg[i-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign trial    = {p_rem, p_nlo[Q_W-1]};
        assign diff     = trial - {1'b0, p_den};
        assign ge       = trial >= {1'b0, p_den};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= p_den;
                nlo_reg[i]  <= {p_nlo[Q_W-2:0], 1'b0};
                quot_reg[i] <= {p_quot[Q_W-2:0], ge};
                side_reg[i] <= p_side;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ===== rtl/butterworth_frequency_mask.sv =====
// ============================================================================
// butterworth_frequency_mask - butterworth transfer gain per frequency bin
// lowpass, highpass, band-reject, band-pass and notch gain in unsigned Q1.16
// ============================================================================
// Takes one centred frequency coordinate per transaction and returns the
// butterworth gain 1/(1+r^n) for it, 65536 meaning 1.0. One coordinate is
// accepted every clock cycle while the output is not stalled. Each passes
// through the distance and ratio operand arithmetic, the bit-per-stage ratio
// divider, the 15 saturating power multipliers, the bit-per-stage gain
// divider and the output register. The whole pipeline advances together and
// holds when the output is stalled. Only squared distances are used. A zero
// ratio denominator gives gain 0 (1.0 for band-pass); unused kinds give 1.0.
// Configuration writes take effect at once and are meant to happen only while
// the pipeline is empty.
module butterworth_frequency_mask (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [bwfm_pkg::CFG_W-1:0]        cfg_data,
    // coordinate stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bwfm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // freq_u, freq_v
    // gain stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bwfm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // gain
);

    import bwfm_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [2:0]                filter_kind_reg;
    logic [9:0]                cutoff_radius_reg;
    logic [3:0]                filter_order_reg;
    logic [9:0]                band_width_reg;
    logic signed [COORD_W-1:0] notch_u_reg;
    logic signed [COORD_W-1:0] notch_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_kind_reg   <= KIND_LOWPASS;
            cutoff_radius_reg <= 10'd32;
            filter_order_reg  <= 4'd2;
            band_width_reg    <= 10'd8;
            notch_u_reg       <= '0;
            notch_v_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KIND:    filter_kind_reg   <= cfg_data[2:0];
                CFG_RADIUS:  cutoff_radius_reg <= cfg_data;
                CFG_ORDER:   filter_order_reg  <= cfg_data[3:0];
                CFG_BAND:    band_width_reg    <= cfg_data;
                CFG_NOTCH_U: notch_u_reg       <= cfg_data;
                CFG_NOTCH_V: notch_v_reg       <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance: everything moves unless the output is held
    // ------------------------------------------------------------------
    logic en;
    logic out_vld_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // stage 1: coordinates and notch offsets
    // ------------------------------------------------------------------
    logic                      v1_reg;
    logic signed [COORD_W-1:0] u1_reg, w1_reg;
    logic signed [COORD_W:0]   a1_reg, b1_reg, c1_reg, e1_reg;
    logic signed [COORD_W-1:0] in_u, in_v;

    assign in_u = s_axis_tdata[COORD_W-1:0];
    assign in_v = s_axis_tdata[2*COORD_W-1:COORD_W];

    // ------------------------------------------------------------------
    // stage 2: squares
    // ------------------------------------------------------------------
    logic        v2_reg;
    logic [18:0] uu2_reg, vv2_reg;
    logic [20:0] aa2_reg, bb2_reg, cc2_reg, ee2_reg;
    logic [19:0] r2_2_reg, w2_2_reg;
    logic signed [19:0] uu_next, vv_next;
    logic signed [21:0] aa_next, bb_next, cc_next, ee_next;

    assign uu_next = u1_reg * u1_reg;
    assign vv_next = w1_reg * w1_reg;
    assign aa_next = a1_reg * a1_reg;
    assign bb_next = b1_reg * b1_reg;
    assign cc_next = c1_reg * c1_reg;
    assign ee_next = e1_reg * e1_reg;

    // ------------------------------------------------------------------
    // stage 3: squared distances
    // ------------------------------------------------------------------
    logic        v3_reg;
    logic [19:0] d2_3_reg, r2_3_reg, w2_3_reg;
    logic [21:0] s1_3_reg, s2_3_reg;

    // ------------------------------------------------------------------
    // stage 4: wide products and ring offset
    // ------------------------------------------------------------------
    logic               v4_reg;
    logic [19:0]        d2_4_reg, r2_4_reg;
    logic signed [20:0] diff4_reg;
    logic [39:0]        dw4_reg, rr4_reg;
    logic [DEN_W-1:0]   ss4_reg;
    logic [43:0]        ss_next;

    assign ss_next = s1_3_reg * s2_3_reg;

    // ------------------------------------------------------------------
    // stage 5: ratio numerator and denominator per kind
    // ------------------------------------------------------------------
    logic               v5_reg;
    logic [NUM_W-1:0]   num5_reg;
    logic [DEN_W-1:0]   den5_reg;
    logic               zero5_reg;
    logic signed [41:0] dd_next;
    logic [NUM_W-1:0]   num_next;
    logic [DEN_W-1:0]   den_next;

    assign dd_next = diff4_reg * diff4_reg;

    always_comb
    begin
        case (filter_kind_reg)
            KIND_LOWPASS:
            begin
                num_next = NUM_W'(d2_4_reg);
                den_next = DEN_W'(r2_4_reg);
            end
            KIND_HIGHPASS:
            begin
                num_next = NUM_W'(r2_4_reg);
                den_next = DEN_W'(d2_4_reg);
            end
            KIND_BANDREJECT, KIND_BANDPASS:
            begin
                num_next = dw4_reg;
                den_next = DEN_W'(dd_next[39:0]);
            end
            KIND_NOTCH:
            begin
                num_next = rr4_reg;
                den_next = ss4_reg;
            end
            default:
            begin
                // unused kinds are overridden at the output
                num_next = '0;
                den_next = DEN_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            u1_reg <= in_u;
            w1_reg <= in_v;
            a1_reg <= {in_u[COORD_W-1], in_u} - {notch_u_reg[COORD_W-1], notch_u_reg};
            b1_reg <= {in_v[COORD_W-1], in_v} - {notch_v_reg[COORD_W-1], notch_v_reg};
            c1_reg <= {in_u[COORD_W-1], in_u} + {notch_u_reg[COORD_W-1], notch_u_reg};
            e1_reg <= {in_v[COORD_W-1], in_v} + {notch_v_reg[COORD_W-1], notch_v_reg};
            // stage 2
            uu2_reg  <= uu_next[18:0];
            vv2_reg  <= vv_next[18:0];
            aa2_reg  <= aa_next[20:0];
            bb2_reg  <= bb_next[20:0];
            cc2_reg  <= cc_next[20:0];
            ee2_reg  <= ee_next[20:0];
            r2_2_reg <= cutoff_radius_reg * cutoff_radius_reg;
            w2_2_reg <= band_width_reg * band_width_reg;
            // stage 3
            d2_3_reg <= {1'b0, uu2_reg} + {1'b0, vv2_reg};
            s1_3_reg <= {1'b0, aa2_reg} + {1'b0, bb2_reg};
            s2_3_reg <= {1'b0, cc2_reg} + {1'b0, ee2_reg};
            r2_3_reg <= r2_2_reg;
            w2_3_reg <= w2_2_reg;
            // stage 4
            d2_4_reg  <= d2_3_reg;
            r2_4_reg  <= r2_3_reg;
            diff4_reg <= $signed({1'b0, d2_3_reg}) - $signed({1'b0, r2_3_reg});
            dw4_reg   <= d2_3_reg * w2_3_reg;
            rr4_reg   <= r2_3_reg * r2_3_reg;
            ss4_reg   <= ss_next[DEN_W-1:0];
            // stage 5
            num5_reg  <= num_next;
            den5_reg  <= den_next;
            zero5_reg <= (den_next == '0);
        end
    end

    // ------------------------------------------------------------------
    // ratio divider: floor(num * 2^F / den), saturating
    // ------------------------------------------------------------------
    localparam int HI_W = NUM_W - (RATIO_W - GAIN_F);

    logic [DEN_W-1:0]   rdiv_rem0;
    logic [RATIO_W-1:0] rdiv_nlo;
    logic               rdiv_sat;
    logic               rdiv_vld;
    logic [RATIO_W-1:0] rdiv_quot;
    logic [1:0]         rdiv_side;

    // quotient bits above the ratio width would mean saturation
    assign rdiv_rem0 = DEN_W'(num5_reg[NUM_W-1:NUM_W-HI_W]);
    assign rdiv_nlo  = {num5_reg[NUM_W-HI_W-1:0], {GAIN_F{1'b0}}};
    assign rdiv_sat  = rdiv_rem0 >= den5_reg;

    bwfm_div_pipe #(
        .DEN_W  (DEN_W),
        .Q_W    (RATIO_W),
        .SIDE_W (2)
    ) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_rem    (rdiv_rem0),
        .in_den    (den5_reg),
        .in_nlo    (rdiv_nlo),
        .in_side   ({zero5_reg, rdiv_sat}),
        .out_valid (rdiv_vld),
        .out_quot  (rdiv_quot),
        .out_side  (rdiv_side)
    );

    // ------------------------------------------------------------------
    // power chain: p = sat_mul(p, r) for each order step below the order
    // two stages per step: partial products, then sum and saturate
    // ------------------------------------------------------------------
    logic               pa_vld_reg [MAX_ORDER];
    logic               pa_zero_reg [MAX_ORDER];
    logic [RATIO_W-1:0] pa_p_reg [MAX_ORDER];
    logic [RATIO_W-1:0] pa_r_reg [MAX_ORDER];
    logic [2*MUL_HI_W-1:0]        pa_hh_reg [MAX_ORDER];
    logic [MUL_HI_W+MUL_LO_W-1:0] pa_hl_reg [MAX_ORDER];
    logic [MUL_HI_W+MUL_LO_W-1:0] pa_lh_reg [MAX_ORDER];
    logic [2*MUL_LO_W-1:0]        pa_ll_reg [MAX_ORDER];

    logic               pb_vld_reg [MAX_ORDER];
    logic               pb_zero_reg [MAX_ORDER];
    logic [RATIO_W-1:0] pb_p_reg [MAX_ORDER];
    logic [RATIO_W-1:0] pb_r_reg [MAX_ORDER];

    localparam int PROD_W = 2 * RATIO_W;

    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_pow
        localparam logic [3:0] STEP = 4'(k);

        logic               src_vld;
        logic               src_zero;
        logic [RATIO_W-1:0] src_p;
        logic [RATIO_W-1:0] src_r;
        logic [PROD_W-1:0]  prod;
        logic               prod_sat;
        logic [RATIO_W-1:0] p_next;

        if (k == 0) begin : g_first
            assign src_vld  = rdiv_vld;
            assign src_zero = rdiv_side[1];
            assign src_p    = RATIO_W'(GAIN_ONE);
            assign src_r    = rdiv_side[0] ? RATIO_CAP : rdiv_quot;
        end
        else begin : g_next
            assign src_vld  = pb_vld_reg[k-1];
            assign src_zero = pb_zero_reg[k-1];
            assign src_p    = pb_p_reg[k-1];
            assign src_r    = pb_r_reg[k-1];
        end

        // product of 2^63 or more saturates the power
        assign prod = (PROD_W'(pa_hh_reg[k]) << (2 * MUL_LO_W))
                    + (PROD_W'(pa_hl_reg[k]) << MUL_LO_W)
                    + (PROD_W'(pa_lh_reg[k]) << MUL_LO_W)
                    + PROD_W'(pa_ll_reg[k]);
        assign prod_sat = |prod[PROD_W-1:RATIO_W+GAIN_F];
        assign p_next   = (filter_order_reg > STEP)
                        ? (prod_sat ? RATIO_CAP : prod[RATIO_W+GAIN_F-1:GAIN_F])
                        : pa_p_reg[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pa_vld_reg[k] <= 1'b0;
                pb_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                pa_vld_reg[k] <= src_vld;
                pb_vld_reg[k] <= pa_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_zero_reg[k] <= src_zero;
                pa_p_reg[k]    <= src_p;
                pa_r_reg[k]    <= src_r;
                pa_hh_reg[k]   <= src_p[RATIO_W-1:MUL_LO_W] * src_r[RATIO_W-1:MUL_LO_W];
                pa_hl_reg[k]   <= src_p[RATIO_W-1:MUL_LO_W] * src_r[MUL_LO_W-1:0];
                pa_lh_reg[k]   <= src_p[MUL_LO_W-1:0] * src_r[RATIO_W-1:MUL_LO_W];
                pa_ll_reg[k]   <= src_p[MUL_LO_W-1:0] * src_r[MUL_LO_W-1:0];
                pb_zero_reg[k] <= pa_zero_reg[k];
                pb_p_reg[k]    <= p_next;
                pb_r_reg[k]    <= pa_r_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // gain divider: round(2^(2F) / (2^F + p)), ties up
    // ------------------------------------------------------------------
    logic [GDEN_W-1:0] gdiv_den;
    logic [GDEN_W-1:0] gdiv_num;
    logic              gdiv_vld;
    logic [GAIN_W-1:0] gdiv_quot;
    logic              gdiv_zero;

    assign gdiv_den = GDEN_W'(pb_p_reg[MAX_ORDER-1]) + GDEN_W'(GAIN_ONE);
    assign gdiv_num = (GDEN_W'(1) << (2 * GAIN_F)) + (gdiv_den >> 1);

    bwfm_div_pipe #(
        .DEN_W  (GDEN_W),
        .Q_W    (GAIN_W),
        .SIDE_W (1)
    ) u_gain_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pb_vld_reg[MAX_ORDER-1]),
        .in_rem    (gdiv_num >> GAIN_W),
        .in_den    (gdiv_den),
        .in_nlo    (gdiv_num[GAIN_W-1:0]),
        .in_side   (pb_zero_reg[MAX_ORDER-1]),
        .out_valid (gdiv_vld),
        .out_quot  (gdiv_quot),
        .out_side  (gdiv_zero)
    );

    // ------------------------------------------------------------------
    // output register: kind fix-ups
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] raw_gain;
    logic [GAIN_W-1:0] gain_next;
    logic [GAIN_W-1:0] gain_reg;

    // infinite ratio gives zero gain
    assign raw_gain = gdiv_zero ? '0 : gdiv_quot;

    always_comb
    begin
        case (filter_kind_reg)
            KIND_LOWPASS, KIND_HIGHPASS, KIND_BANDREJECT, KIND_NOTCH:
                gain_next = raw_gain;
            KIND_BANDPASS:
                gain_next = GAIN_ONE - raw_gain;
            default:
                gain_next = GAIN_ONE;   // unused kinds pass everything
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= gdiv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gain_reg <= gain_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(gain_reg);

endmodule

// ===== bench/tb_butterworth_frequency_mask.sv =====
// ============================================================================
// tb_butterworth_frequency_mask - self-checking bench for the gain mask
// drives coordinate transactions under random bursts and output stalls,
// predicts each butterworth gain in 64-bit fixed point and compares in order
// ============================================================================
module tb_butterworth_frequency_mask;
    timeunit 1ns;
    timeprecision 1ps;

    import bwfm_pkg::*;

    localparam longint unsigned R_CAP    = (64'd1 << (63 - GAIN_F)) - 64'd1;
    localparam longint unsigned PROD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned ONE_G    = 64'd1 << GAIN_F;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [2:0]               cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata;    // freq_u [9:0], freq_v [19:10], zero pad
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;    // gain [16:0], zero pad

    butterworth_frequency_mask dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow copy of the filter settings
    logic [2:0]  mask_kind;
    int unsigned mask_radius;
    int unsigned mask_order;
    int unsigned mask_band;
    int          mask_nu;
    int          mask_nv;

    logic [GAIN_W-1:0] gain_queue[$];   // gains still owed by the block
    int                errors;
    int                burst_left;
    int unsigned       cycle_cnt = 0;

    // ------------------------------------------------------------------
    // clock, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("butterworth_frequency_mask test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // gain predictor
    // ------------------------------------------------------------------
    // squared ratio num/den in gain format, truncated, saturating
    function automatic longint unsigned ratio_q(longint unsigned num, longint unsigned den);
        bit [127:0] q;
        q = ({64'd0, num} << GAIN_F) / den;
        return (q > R_CAP) ? R_CAP : q[63:0];
    endfunction

    function automatic longint unsigned power_step(longint unsigned a, longint unsigned b);
        if (a != 0 && b > PROD_MAX / a)
            return R_CAP;
        return (a * b) >> GAIN_F;
    endfunction

    // 1/(1+(num/den)^n), zero denominator means infinite ratio
    function automatic longint unsigned butter_gain(longint unsigned num, longint unsigned den);
        longint unsigned r, p, d;
        if (den == 0)
            return 0;
        r = ratio_q(num, den);
        p = ONE_G;
        for (int k = 0; k < mask_order; k++)
            p = power_step(p, r);
        d = ONE_G + p;
        return ((64'd1 << (2 * GAIN_F)) + (d >> 1)) / d;
    endfunction

    function automatic logic [GAIN_W-1:0] predict_gain(int u, int v);
        longint          su, sv, diff, a, b, c, e;
        longint unsigned d2, r2, g;
        su = u;
        sv = v;
        d2 = su * su + sv * sv;
        r2 = longint'(mask_radius) * mask_radius;
        case (mask_kind)
            KIND_LOWPASS:  g = butter_gain(d2, r2);
            KIND_HIGHPASS: g = butter_gain(r2, d2);
            KIND_BANDREJECT, KIND_BANDPASS:
            begin
                diff = longint'(d2) - longint'(r2);
                g = butter_gain(d2 * (longint'(mask_band) * mask_band), diff * diff);
                if (mask_kind == KIND_BANDPASS)
                    g = ONE_G - g;
            end
            KIND_NOTCH:
            begin
                a = su - mask_nu;
                b = sv - mask_nv;
                c = su + mask_nu;
                e = sv + mask_nv;
                g = butter_gain(r2 * r2, (a * a + b * b) * (c * c + e * e));
            end
            default: g = ONE_G;   // spare kinds pass everything
        endcase
        return g[GAIN_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // receiver stall pattern, changes character in turn among four patterns
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        case ((cycle_cnt / 300) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(1, 0));
            2: m_axis_tready <= (cycle_cnt % 16) < 9;
            default: m_axis_tready <= (cycle_cnt % 8) != 0;
        endcase
    end

    // ------------------------------------------------------------------
    // result checker, sampled at negedge so the handshake is settled
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic [GAIN_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (gain_queue.size() == 0)
            begin
                $display("%0t: unexpected gain transaction, actual %0d", $realtime,
                         m_axis_tdata[GAIN_W-1:0]);
                errors++;
            end
            else
            begin
                want = gain_queue.pop_front();
                if (m_axis_tdata[GAIN_W-1:0] !== want)
                begin
                    $display("%0t: gain mismatch, expected %0d actual %0d", $realtime,
                             want, m_axis_tdata[GAIN_W-1:0]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared helpers
    // ------------------------------------------------------------------
    // one coordinate transaction; valid stays high for a back-to-back call
    task automatic send_coord(int u, int v);
        logic acc;
        if (burst_left == 0)
        begin
            int gap;
            gap = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, 10'(v), 10'(u)};
        do
        begin
            @(negedge clk);
            acc = s_axis_tready;
            @(posedge clk);
        end
        while (!acc);
        gain_queue.push_back(predict_gain(u, v));
    endtask

    // stop sending and let every owed gain come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (gain_queue.size() != 0)
            @(posedge clk);
    endtask

    // register write, only done with the pipeline empty
    task automatic write_reg(logic [2:0] idx, int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_KIND:    mask_kind   = 3'(value);
            CFG_RADIUS:  mask_radius = value & 10'h3FF;
            CFG_ORDER:   mask_order  = value & 4'hF;
            CFG_BAND:    mask_band   = value & 10'h3FF;
            CFG_NOTCH_U: mask_nu     = $signed(10'(value));
            CFG_NOTCH_V: mask_nv     = $signed(10'(value));
            default: ;
        endcase
    endtask

    task automatic set_mask(logic [2:0] kind, int radius, int order, int band, int nu, int nv);
        write_reg(CFG_KIND, kind);
        write_reg(CFG_RADIUS, radius);
        write_reg(CFG_ORDER, order);
        write_reg(CFG_BAND, band);
        write_reg(CFG_NOTCH_U, nu);
        write_reg(CFG_NOTCH_V, nv);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset settings: lowpass, radius 32, order 2, coordinate extremes
    task automatic test_reset_settings();
        send_coord(0, 0);
        send_coord(-512, -512);
        send_coord(511, 511);
        send_coord(32, 0);
        send_coord(-20, 25);
    endtask

    // each kind, including the spare codes
    task automatic test_every_kind();
        set_mask(KIND_HIGHPASS, 40, 3, 8, 0, 0);
        send_coord(30, -10);
        send_coord(0, 0);                       // zero distance, infinite ratio
        set_mask(KIND_BANDREJECT, 5, 2, 3, 0, 0);
        send_coord(3, 4);                       // on the ring, zero denominator
        send_coord(7, -1);
        set_mask(KIND_BANDPASS, 5, 2, 3, 0, 0);
        send_coord(-4, 3);                      // band-pass of infinite ratio is 1.0
        send_coord(0, 0);                       // zero numerator, band-pass 0
        set_mask(KIND_NOTCH, 10, 1, 8, -100, 37);
        send_coord(-100, 37);                   // on the notch centre
        send_coord(100, -37);                   // on the mirrored centre
        send_coord(50, 50);
        for (int k = 5; k < 8; k++)
        begin
            write_reg(CFG_KIND, k);
            send_coord(k, -k);
        end
    endtask

    // order zero and fifteen, radius zero and full scale
    task automatic test_order_and_radius_extremes();
        set_mask(KIND_LOWPASS, 0, 0, 0, 0, 0);
        send_coord(1, 1);                       // zero denominator beats order zero
        set_mask(KIND_LOWPASS, 1023, 0, 1023, 511, -512);
        send_coord(-512, 511);
        write_reg(CFG_ORDER, 15);
        send_coord(511, -512);
        send_coord(0, 0);
        write_reg(CFG_KIND, KIND_HIGHPASS);
        send_coord(1, 0);                       // huge ratio saturates the power
        write_reg(CFG_KIND, KIND_NOTCH);
        send_coord(3, -2);
    endtask

    // random settings per phase; coordinates mostly near the cutoff
    task automatic test_random_phases(int phases, int per_phase);
        int r, u, v;
        for (int p = 0; p < phases; p++)
        begin
            case (p % 5)
                0: r = 0;
                1: r = 1023;
                default: r = $urandom_range(120, 1);
            endcase
            set_mask(3'($urandom_range(p % 9 == 8 ? 7 : 4, 0)), r,
                     (p % 7 == 3) ? 15 : (p % 7 == 5 ? 0 : $urandom_range(6, 1)),
                     $urandom_range(3, 0) == 0 ? $urandom_range(1023, 0)
                                               : $urandom_range(40, 0),
                     $urandom_range(3, 0) == 0 ? $urandom_range(1023, 0) - 512
                                               : $urandom_range(60, 0) - 30,
                     $urandom_range(3, 0) == 0 ? $urandom_range(1023, 0) - 512
                                               : $urandom_range(60, 0) - 30);
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(3, 0) == 0)
                begin
                    u = $urandom_range(1023, 0) - 512;
                    v = $urandom_range(1023, 0) - 512;
                end
                else if (mask_kind == KIND_NOTCH && $urandom_range(4, 0) == 0)
                begin
                    // around either notch centre
                    u = mask_nu + $urandom_range(8, 0) - 4;
                    v = mask_nv + $urandom_range(8, 0) - 4;
                    if ($urandom_range(1, 0))
                    begin
                        u = -u;
                        v = -v;
                    end
                end
                else
                begin
                    u = $urandom_range(2 * (r > 200 ? 200 : r) + 8, 0) - (r > 200 ? 200 : r) - 4;
                    v = $urandom_range(2 * (r > 200 ? 200 : r) + 8, 0) - (r > 200 ? 200 : r) - 4;
                end
                u = u > 511 ? 511 : (u < -512 ? -512 : u);
                v = v > 511 ? 511 : (v < -512 ? -512 : v);
                send_coord(u, v);
                // hold the sender once until the pipeline is empty
                if (p == 2 && i == per_phase / 2)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (gain_queue.size() != 0)
                        @(posedge clk);
                    burst_left = 0;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int waited;
        errors        = 0;
        burst_left    = 0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_KIND;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        mask_kind     = KIND_LOWPASS;
        mask_radius   = 32;
        mask_order    = 2;
        mask_band     = 8;
        mask_nu       = 0;
        mask_nv       = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_every_kind();
        test_order_and_radius_extremes();
        test_random_phases(13, 148);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (gain_queue.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        if (gain_queue.size() != 0)
        begin
            $display("%0t: %0d gains never arrived", $realtime, gain_queue.size());
            errors++;
        end
        repeat (150) @(posedge clk);   // catch any stray output past the latency

        if (errors == 0)
            $display("butterworth_frequency_mask test passed");
        else
            $display("butterworth_frequency_mask test failed");
        $finish;
    end

endmodule
